### rtl/sgfs_pkg.sv
`default_nettype none
package sgfs_pkg;

  // Number format
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int MAG_W     = COORD_W + 1;

  // Shared serial multiplier: multiplicand A, multiplier B, one B bit per cycle
  localparam int MUL_A_W   = 67;
  localparam int MUL_B_W   = 35;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // Square root of the softened distance, two radicand bits per cycle
  localparam int D_W        = MUL_A_W;
  localparam int ROOT_W     = MUL_B_W;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

  // Restoring divider, one quotient bit per cycle
  localparam int GM_W      = 2 * COORD_W;
  localparam int NUM_W     = GM_W + COORD_W + FRAC_BITS;
  localparam int DEN_W     = MUL_P_W;
  localparam int ACC_W     = 48;
  localparam int QUOT_W    = ACC_W - 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT = 2'd1;

  // Divider result: clamp flag and quotient below the clamp limit
  typedef struct packed {
    logic              sat;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage
`default_nettype wire

### rtl/sgfs_smul.sv
`default_nettype none
module sgfs_smul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic [sgfs_pkg::MUL_A_W-1:0]  a,
  input  wire logic [sgfs_pkg::MUL_B_W-1:0]  b,
  output logic                               done,
  output logic [sgfs_pkg::MUL_P_W-1:0]       prod
);

  logic [sgfs_pkg::MUL_A_W-1:0]   hi;
  logic [sgfs_pkg::MUL_B_W-1:0]   lo;
  logic [sgfs_pkg::MUL_A_W-1:0]   mcand;
  logic [sgfs_pkg::MUL_CNT_W-1:0] cnt;
  logic                           busy;
  logic [sgfs_pkg::MUL_A_W:0]     psum;

  // Add the multiplicand when the low multiplier bit is set
  assign psum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, lo};

  // Shift the partial product right one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        hi    <= '0;
        lo    <= b;
        mcand <= a;
        cnt   <= sgfs_pkg::MUL_CNT_W'(sgfs_pkg::MUL_B_W);
        busy  <= 1'b1;
      end else if (busy) begin
        hi  <= psum[sgfs_pkg::MUL_A_W:1];
        lo  <= {psum[0], lo[sgfs_pkg::MUL_B_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == sgfs_pkg::MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/sgfs_sqrt.sv
`default_nettype none
module sgfs_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic [sgfs_pkg::D_W-1:0]    rad_in,
  output logic                             done,
  output logic [sgfs_pkg::ROOT_W-1:0]      root
);

  logic [sgfs_pkg::RAD_W-1:0]      rad;
  logic [sgfs_pkg::SREM_W-1:0]     rem;
  logic [sgfs_pkg::SQRT_CNT_W-1:0] cnt;
  logic                            busy;
  logic [sgfs_pkg::SREM_W+1:0]     shifted;
  logic [sgfs_pkg::SREM_W+1:0]     trial;
  logic [sgfs_pkg::SREM_W+2:0]     diff;

  // Bring down two radicand bits and try the next root bit
  assign shifted = {rem, rad[sgfs_pkg::RAD_W-1 -: 2]};
  assign trial   = (sgfs_pkg::SREM_W+2)'({root, 2'b01});
  assign diff    = {1'b0, shifted} - {1'b0, trial};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rad  <= sgfs_pkg::RAD_W'(rad_in);
        rem  <= '0;
        root <= '0;
        cnt  <= sgfs_pkg::SQRT_CNT_W'(sgfs_pkg::ROOT_W);
        busy <= 1'b1;
      end else if (busy) begin
        rad <= {rad[sgfs_pkg::RAD_W-3:0], 2'b00};
        if (!diff[sgfs_pkg::SREM_W+2]) begin
          rem  <= diff[sgfs_pkg::SREM_W-1:0];
          root <= {root[sgfs_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= shifted[sgfs_pkg::SREM_W-1:0];
          root <= {root[sgfs_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == sgfs_pkg::SQRT_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/sgfs_sdiv.sv
`default_nettype none
module sgfs_sdiv (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic [sgfs_pkg::NUM_W-1:0]  num,
  input  wire logic [sgfs_pkg::DEN_W-1:0]  den,
  output logic                             done,
  output sgfs_pkg::div_res_t               res
);

  logic [sgfs_pkg::NUM_W-1:0]     nsh;
  logic [sgfs_pkg::DEN_W-1:0]     dsor;
  logic [sgfs_pkg::DEN_W-1:0]     rem;
  logic [sgfs_pkg::QUOT_W:0]      q;
  logic                           sat;
  logic [sgfs_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [sgfs_pkg::DEN_W:0]       trial;
  logic [sgfs_pkg::DEN_W+1:0]     diff;

  // Bring down one dividend bit and compare against the divisor
  assign trial = {rem, nsh[sgfs_pkg::NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsor};

  assign res.sat  = sat | q[sgfs_pkg::QUOT_W];
  assign res.quot = q[sgfs_pkg::QUOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        nsh  <= num;
        dsor <= den;
        rem  <= '0;
        q    <= '0;
        sat  <= 1'b0;
        cnt  <= sgfs_pkg::DIV_CNT_W'(sgfs_pkg::NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        nsh <= {nsh[sgfs_pkg::NUM_W-2:0], 1'b0};
        // Keep a sticky clamp flag for quotient bits above the limit
        sat <= sat | q[sgfs_pkg::QUOT_W];
        if (!diff[sgfs_pkg::DEN_W+1]) begin
          rem <= diff[sgfs_pkg::DEN_W-1:0];
          q   <= {q[sgfs_pkg::QUOT_W-1:0], 1'b1};
        end else begin
          rem <= trial[sgfs_pkg::DEN_W-1:0];
          q   <= {q[sgfs_pkg::QUOT_W-1:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == sgfs_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/softened_gravity_field_sampler.sv
// Channel   Group            Word contents
// input     s_axis_*         query x/y/z, body x/y/z, mass in tdata; last body in tlast
// output    m_axis_*         accel x/y/z in tdata; overflow in tuser
// config    cfg_we/index/data  grav_const (0), softening (1)
//
// A zero-mass body skips the arithmetic, and one with zero softened distance stops after
// its squares. Any other body takes nine passes of the shared bit-serial multiplier, the
// serial root, three divider passes, one add per axis and the closing step.
// Reset (rst, synchronous) clears the sums and the output valid, and loads register defaults.
// A finished result waits in the output register while the next body is taken;
// a last body that finds that register still full waits until it drains.
`default_nettype none
module softened_gravity_field_sampler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // query_x, query_y, query_z, body_x, body_y, body_z, body_mass
  input  wire logic [223:0]                    s_axis_tdata,
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // accel_x, accel_y, accel_z
  output logic [95:0]                          m_axis_tdata,
  // overflow
  output logic                                 m_axis_tuser,
  input  wire logic                            cfg_we,
  input  wire logic [sgfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_data
);

  typedef enum logic [3:0] {
    P_IDLE, P_SQX, P_SQY, P_SQZ, P_SQE, P_ROOT, P_DEN, P_GM,
    P_NUM, P_DIV, P_ACC, P_FIN
  } phase_t;

  localparam logic signed [sgfs_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(sgfs_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [sgfs_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(sgfs_pkg::ACC_W-1){1'b0}}};

  phase_t state;

  logic [31:0]                       g;
  logic [31:0]                       eps;
  logic [sgfs_pkg::MAG_W-1:0]        mag [3];
  logic [2:0]                        neg;
  logic                              last;
  logic [31:0]                       gm_mass;
  logic [sgfs_pkg::D_W-1:0]          d;
  logic [sgfs_pkg::DEN_W-1:0]        den;
  logic [sgfs_pkg::GM_W-1:0]         gm;
  logic [1:0]                        ax;
  logic signed [sgfs_pkg::ACC_W-1:0] sum [3];
  logic                              out_valid;
  logic [95:0]                       out_data;
  logic                              out_ovf;

  logic                              go_mul, go_sqrt, go_div;
  logic                              mul_done, sqrt_done, div_done;
  logic [sgfs_pkg::MUL_A_W-1:0]      mul_a;
  logic [sgfs_pkg::MUL_B_W-1:0]      mul_b;
  logic [sgfs_pkg::MUL_P_W-1:0]      prod;
  logic [sgfs_pkg::ROOT_W-1:0]       root;
  sgfs_pkg::div_res_t                dres;

  logic [sgfs_pkg::D_W-1:0]          d_sum;
  logic [sgfs_pkg::ACC_W-1:0]        tmag;
  logic signed [sgfs_pkg::ACC_W:0]   tsig;
  logic signed [sgfs_pkg::ACC_W:0]   s49;
  logic signed [sgfs_pkg::ACC_W-1:0] acc_sat;
  logic                              out_free;
  logic                              out_load;
  logic signed [sgfs_pkg::MAG_W-1:0] rdiff [3];
  logic [32:0]                       ex, ey, ez;

  // Clamp a sum to 32 bits, with the clamp flag on top
  function automatic logic [32:0] sat32(input logic signed [sgfs_pkg::ACC_W-1:0] v);
    logic [32:0] r;
    if (v > sgfs_pkg::ACC_W'(signed'(33'sh0_7FFF_FFFF))) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < sgfs_pkg::ACC_W'(signed'(33'sh1_8000_0000))) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  assign s_axis_tready = (state == P_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_ovf;
  assign out_free      = !out_valid || m_axis_tready;
  assign out_load      = (state == P_FIN) && last && out_free;

  // Offsets body minus query, one per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rdiff[i] = sgfs_pkg::MAG_W'(signed'(s_axis_tdata[96+32*i +: 32]))
               - sgfs_pkg::MAG_W'(signed'(s_axis_tdata[32*i +: 32]));
    end
  end

  // Pick the multiplier operands for the running step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      P_SQX: begin
        mul_a = sgfs_pkg::MUL_A_W'(mag[0]);
        mul_b = sgfs_pkg::MUL_B_W'(mag[0]);
      end
      P_SQY: begin
        mul_a = sgfs_pkg::MUL_A_W'(mag[1]);
        mul_b = sgfs_pkg::MUL_B_W'(mag[1]);
      end
      P_SQZ: begin
        mul_a = sgfs_pkg::MUL_A_W'(mag[2]);
        mul_b = sgfs_pkg::MUL_B_W'(mag[2]);
      end
      P_SQE: begin
        mul_a = sgfs_pkg::MUL_A_W'(eps);
        mul_b = sgfs_pkg::MUL_B_W'(eps);
      end
      P_DEN: begin
        mul_a = d;
        mul_b = root;
      end
      P_GM: begin
        mul_a = sgfs_pkg::MUL_A_W'(g);
        mul_b = sgfs_pkg::MUL_B_W'(gm_mass);
      end
      P_NUM: begin
        mul_a = sgfs_pkg::MUL_A_W'(gm);
        mul_b = sgfs_pkg::MUL_B_W'(mag[ax]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign d_sum = d + prod[sgfs_pkg::D_W-1:0];

  // Signed, clamped contribution of the current axis
  assign tmag    = dres.sat ? ACC_MAX : {1'b0, dres.quot};
  assign tsig    = neg[ax] ? -signed'({1'b0, tmag}) : signed'({1'b0, tmag});
  assign s49     = {sum[ax][sgfs_pkg::ACC_W-1], sum[ax]} + tsig;
  assign acc_sat = (s49[sgfs_pkg::ACC_W] ^ s49[sgfs_pkg::ACC_W-1])
                 ? (s49[sgfs_pkg::ACC_W] ? ACC_MIN : ACC_MAX)
                 : s49[sgfs_pkg::ACC_W-1:0];

  assign ex = sat32(sum[0]);
  assign ey = sat32(sum[1]);
  assign ez = sat32(sum[2]);

  sgfs_smul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (go_mul),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (prod)
  );

  sgfs_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .go     (go_sqrt),
    .rad_in (d),
    .done   (sqrt_done),
    .root   (root)
  );

  sgfs_sdiv u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (go_div),
    .num  ({prod[sgfs_pkg::GM_W+sgfs_pkg::COORD_W-1:0], {sgfs_pkg::FRAC_BITS{1'b0}}}),
    .den  (den),
    .done (div_done),
    .res  (dres)
  );

  // Sequence one body through the serial units
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= P_IDLE;
      go_mul    <= 1'b0;
      go_sqrt   <= 1'b0;
      go_div    <= 1'b0;
      g         <= 32'd65536;
      eps       <= 32'd16384;
      sum[0]    <= '0;
      sum[1]    <= '0;
      sum[2]    <= '0;
      out_valid <= 1'b0;
      ax        <= '0;
      last      <= 1'b0;
    end else begin
      go_mul  <= 1'b0;
      go_sqrt <= 1'b0;
      go_div  <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          sgfs_pkg::REG_GRAV: g   <= cfg_data;
          sgfs_pkg::REG_SOFT: eps <= cfg_data;
          default: ;
        endcase
      end
      // Load a finished result, or drop the word once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        P_IDLE: begin
          if (s_axis_tvalid) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= rdiff[i][sgfs_pkg::MAG_W-1];
              mag[i] <= rdiff[i][sgfs_pkg::MAG_W-1] ? -rdiff[i] : rdiff[i];
            end
            gm_mass <= s_axis_tdata[223:192];
            last    <= s_axis_tlast;
            d       <= '0;
            ax      <= '0;
            if (s_axis_tdata[223:192] == 32'd0) begin
              state <= P_FIN;
            end else begin
              state  <= P_SQX;
              go_mul <= 1'b1;
            end
          end
        end
        P_SQX, P_SQY, P_SQZ: begin
          if (mul_done) begin
            d      <= d_sum;
            go_mul <= 1'b1;
            state  <= (state == P_SQX) ? P_SQY : ((state == P_SQY) ? P_SQZ : P_SQE);
          end
        end
        P_SQE: begin
          if (mul_done) begin
            d <= d_sum;
            // Drop the body when the softened distance is zero
            if (d_sum == '0) begin
              state <= P_FIN;
            end else begin
              state   <= P_ROOT;
              go_sqrt <= 1'b1;
            end
          end
        end
        P_ROOT: begin
          if (sqrt_done) begin
            state  <= P_DEN;
            go_mul <= 1'b1;
          end
        end
        P_DEN: begin
          if (mul_done) begin
            den    <= prod;
            state  <= P_GM;
            go_mul <= 1'b1;
          end
        end
        P_GM: begin
          if (mul_done) begin
            gm     <= prod[sgfs_pkg::GM_W-1:0];
            state  <= P_NUM;
            go_mul <= 1'b1;
          end
        end
        P_NUM: begin
          if (mul_done) begin
            state  <= P_DIV;
            go_div <= 1'b1;
          end
        end
        P_DIV: begin
          if (div_done) begin
            state <= P_ACC;
          end
        end
        P_ACC: begin
          sum[ax] <= acc_sat;
          if (ax == 2'd2) begin
            state <= P_FIN;
          end else begin
            ax     <= ax + 1'b1;
            state  <= P_NUM;
            go_mul <= 1'b1;
          end
        end
        P_FIN: begin
          if (!last) begin
            state <= P_IDLE;
          end else if (out_free) begin
            out_data  <= {ez[31:0], ey[31:0], ex[31:0]};
            out_ovf   <= ex[32] | ey[32] | ez[32];
            sum[0]    <= '0;
            sum[1]    <= '0;
            sum[2]    <= '0;
            state     <= P_IDLE;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  a_mul_phase: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == P_SQX || state == P_SQY || state == P_SQZ || state == P_SQE ||
                  state == P_DEN || state == P_GM || state == P_NUM))
    else $error("multiplier finished outside a multiply step");

  a_sqrt_phase: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == P_ROOT))
    else $error("square root finished outside its step");

  a_div_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == P_DIV))
    else $error("divider finished outside its step");

  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    (state == P_FIN && last && out_free) |=>
      (m_axis_tvalid && sum[0] == '0 && sum[1] == '0 && sum[2] == '0))
    else $error("emitted result without clearing the sums");

endmodule
`default_nettype wire
